>>> hw/rtl/gj_pkg.sv
// gj_pkg: shared types, constants and helpers of the gauss-jordan inverse block
// used by gj_div, gj_msub and matrix_inverse_gauss_jordan; depends on nothing
package gj_pkg;

  localparam int DATA_W  = 32;
  localparam int SIZE_W  = 4;
  localparam int THR_W   = 17;
  localparam int FRAC_W  = 16;
  localparam int CIDX_W  = 2;

  localparam logic [CIDX_W-1:0] REG_MATRIX_SIZE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_THRESHOLD   = 2'd1;

  localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] S_MAX  = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S_MIN  = 32'sh8000_0000;

  // request to the divider: start pulse and operands
  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] p;
  } div_req_t;

  // magnitude of a signed word, full range fits unsigned
  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = v[DATA_W-1] ? (~v + 32'd1) : v;
    return r;
  endfunction

endpackage

>>> hw/rtl/gj_store.sv
// gj_store: augmented [A|I] store, one write port, two registered read ports
// depends on nothing
module gj_store #(
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [31:0]       wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [31:0]       rdata_a,
  output logic [31:0]       rdata_b
);

  logic [31:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hw/rtl/gj_div.sv
// gj_div: bit-serial rounded q16.16 divide (x * 2^16 + |p|/2) / |p|, saturated
// depends on gj_pkg
module gj_div (
  input  logic                            clk,
  input  logic                            rst,
  input  gj_pkg::div_req_t                req,
  output logic                            done,
  output logic signed [gj_pkg::DATA_W-1:0] q
);

  localparam int NUM_W = 49;

  logic              run;
  logic [5:0]        cnt;
  logic [NUM_W-1:0]  num;
  logic [31:0]       rem;
  logic [NUM_W-1:0]  quo;
  logic [31:0]       mp;
  logic              neg;
  logic [32:0]       rem_sh;
  logic              ge;

  assign rem_sh = {rem, num[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, mp});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(NUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mp  <= gj_pkg::mag32(req.p);
      num <= {1'b0, gj_pkg::mag32(req.x), 16'd0} + NUM_W'(gj_pkg::mag32(req.p) >> 1);
      rem <= '0;
      quo <= '0;
      neg <= req.x[31] ^ req.p[31];
    end else if (run) begin
      rem <= ge ? 32'(rem_sh - {1'b0, mp}) : rem_sh[31:0];
      quo <= {quo[NUM_W-2:0], ge};
      num <= {num[NUM_W-2:0], 1'b0};
    end
  end

  always_comb begin
    if (neg) begin
      q = (quo > NUM_W'(49'h0_8000_0000)) ? gj_pkg::S_MIN : (32'd0 - quo[31:0]);
    end else begin
      q = (quo > NUM_W'(49'h0_7fff_ffff)) ? gj_pkg::S_MAX : quo[31:0];
    end
  end

endmodule

>>> hw/rtl/gj_msub.sv
// gj_msub: a - round(f * b / 2^16), registered product then saturating subtract
// depends on gj_pkg
module gj_msub (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [gj_pkg::DATA_W-1:0] f,
  input  logic signed [gj_pkg::DATA_W-1:0] a,
  input  logic signed [gj_pkg::DATA_W-1:0] b,
  output logic signed [gj_pkg::DATA_W-1:0] res
);

  logic [63:0]        prod;
  logic               neg;
  logic signed [31:0] a_q;
  logic [47:0]        qm;
  logic signed [49:0] d;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= gj_pkg::mag32(f) * gj_pkg::mag32(b);
      neg  <= f[31] ^ b[31];
      a_q  <= a;
    end
  end

  always_comb begin
    qm = 48'((prod + 64'h8000) >> gj_pkg::FRAC_W);
    if (neg) begin
      d = 50'(a_q) + $signed({2'b00, qm});
    end else begin
      d = 50'(a_q) - $signed({2'b00, qm});
    end
    if (d > 50'(gj_pkg::S_MAX)) begin
      res = gj_pkg::S_MAX;
    end else if (d < 50'(gj_pkg::S_MIN)) begin
      res = gj_pkg::S_MIN;
    end else begin
      res = d[31:0];
    end
  end

endmodule

>>> hw/rtl/matrix_inverse_gauss_jordan.sv
// matrix_inverse_gauss_jordan: gauss-jordan inverse with partial pivoting, q16.16
// depends on gj_pkg, gj_store, gj_div, gj_msub
//
// usage
//   config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes matrix_size and
//   singular_threshold; cfg_ready is always high, write only while idle.
//   writing matrix_size restarts the load of the current matrix.
//   input items: matrix_element row-major, taken when start is high and busy low,
//   one per cycle while loading; n*n items fill the matrix.
//   the item that completes the matrix raises busy and starts the run:
//     identity fill, then per column a pivot scan of the n-i remaining rows,
//     a row divide of 2n elements, one at a time (serial 49-step divider),
//     and (n-1) row eliminations of 2n elements each (one multiply per element);
//   then the inverse comes out item by item, or one singular item.
//   results: result_strobe high for exactly one cycle per item; the receiver
//   cannot stall, the block never waits on it. last_result marks the final item.
//   reset (rst, synchronous) clears the load position, row order and sequencer;
//   the store itself is not cleared, a full load writes every entry a run reads.
module matrix_inverse_gauss_jordan #(
  parameter int MAX_ORDER = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gj_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [gj_pkg::DATA_W-1:0] matrix_element,
  output logic                             result_strobe,
  output logic signed [gj_pkg::DATA_W-1:0] inverse_element,
  output logic                             status,
  output logic                             last_result
);

  localparam int ROW_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int COL_W  = $clog2(2 * MAX_ORDER);
  localparam int CNT_W  = $clog2(MAX_ORDER + 1);
  localparam int ADDR_W = ROW_W + COL_W;

  // sequencer, one-hot
  typedef enum logic [14:0] {
    S_LOAD      = 15'b000000000000001,
    S_INIT      = 15'b000000000000010,
    S_PIV_ISS   = 15'b000000000000100,
    S_PIV_CMP   = 15'b000000000001000,
    S_SWAP      = 15'b000000000010000,
    S_DIV_ISS   = 15'b000000000100000,
    S_DIV_START = 15'b000000001000000,
    S_DIV_WAIT  = 15'b000000010000000,
    S_ELF_ISS   = 15'b000000100000000,
    S_ELF_CAP   = 15'b000001000000000,
    S_EL_ISS    = 15'b000010000000000,
    S_EL_MUL    = 15'b000100000000000,
    S_EL_SUB    = 15'b001000000000000,
    S_OUT_ISS   = 15'b010000000000000,
    S_OUT_SHOW  = 15'b100000000000000
  } state_t;

  state_t state;

  // configuration
  logic [gj_pkg::SIZE_W-1:0] matrix_size;
  logic [gj_pkg::THR_W-1:0]  singular_threshold;

  // effective order and the derived end marks
  logic [CNT_W-1:0] n_eff;
  logic [ROW_W-1:0] nm1;
  logic [COL_W-1:0] two_nm1;

  always_comb begin
    if (matrix_size == '0) begin
      n_eff = CNT_W'(1);
    end else if (matrix_size > gj_pkg::SIZE_W'(MAX_ORDER)) begin
      n_eff = CNT_W'(MAX_ORDER);
    end else begin
      n_eff = CNT_W'(matrix_size);
    end
  end
  assign nm1     = ROW_W'(n_eff - CNT_W'(1));
  assign two_nm1 = COL_W'({n_eff, 1'b0} - (CNT_W + 1)'(1));

  // loop counters and run registers
  logic [ROW_W-1:0] lrow, lcol;         // load position
  logic [ROW_W-1:0] r, c;               // identity fill and output walk
  logic [ROW_W-1:0] i, k, best;         // pivot column, row walk, best candidate
  logic [COL_W-1:0] j;                  // element walk across [A|I]
  logic [ROW_W-1:0] pr, kr;             // physical pivot row, physical target row
  logic [31:0]      bmag;
  logic signed [31:0] bval;             // pivot value once the scan ends
  logic signed [31:0] f;                // elimination factor
  logic [ROW_W-1:0] row_order [MAX_ORDER];

  // store ports
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [31:0]       wdata, rdata_a, rdata_b;

  gj_pkg::div_req_t  dreq;
  logic              div_done;
  logic signed [31:0] div_q;
  logic              msub_en;
  logic signed [31:0] msub_res;

  gj_store #(.ADDR_W(ADDR_W)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(rdata_a), .rdata_b(rdata_b)
  );

  gj_div u_div (
    .clk(clk), .rst(rst), .req(dreq), .done(div_done), .q(div_q)
  );

  gj_msub u_msub (
    .clk(clk), .en(msub_en), .f(f), .a(rdata_a), .b(rdata_b), .res(msub_res)
  );

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_LOAD);

  // combinational store and unit control
  always_comb begin
    we        = 1'b0;
    waddr     = {lrow, COL_W'(lcol)};
    wdata     = matrix_element;
    raddr_a   = {row_order[k], COL_W'(i)};
    raddr_b   = {pr, j};
    dreq.start = 1'b0;
    dreq.x     = rdata_a;
    dreq.p     = bval;
    msub_en    = 1'b0;
    case (state)
      S_LOAD: begin
        we = start;
      end
      S_INIT: begin
        we    = 1'b1;
        waddr = {r, COL_W'(n_eff) + COL_W'(c)};
        wdata = (r == c) ? gj_pkg::Q_ONE : 32'd0;
      end
      S_DIV_ISS: begin
        raddr_a = {pr, j};
      end
      S_DIV_START: begin
        dreq.start = 1'b1;
      end
      S_DIV_WAIT: begin
        we    = div_done;
        waddr = {pr, j};
        wdata = div_q;
      end
      S_EL_ISS: begin
        raddr_a = {kr, j};
      end
      S_EL_MUL: begin
        msub_en = 1'b1;
      end
      S_EL_SUB: begin
        we    = 1'b1;
        waddr = {kr, j};
        wdata = msub_res;
      end
      S_OUT_ISS: begin
        raddr_a = {row_order[r], COL_W'(n_eff) + COL_W'(c)};
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_LOAD;
      matrix_size        <= gj_pkg::SIZE_W'(8);
      singular_threshold <= gj_pkg::THR_W'(1);
      lrow               <= '0;
      lcol               <= '0;
      result_strobe      <= 1'b0;
      for (int t = 0; t < MAX_ORDER; t++) begin
        row_order[t] <= ROW_W'(t);
      end
    end else begin
      result_strobe <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gj_pkg::REG_MATRIX_SIZE) begin
          matrix_size <= cfg_data[gj_pkg::SIZE_W-1:0];
          lrow        <= '0;
          lcol        <= '0;
        end else if (cfg_index == gj_pkg::REG_THRESHOLD) begin
          singular_threshold <= cfg_data[gj_pkg::THR_W-1:0];
        end
      end

      case (state)
        S_LOAD: begin
          if (start) begin
            if (lcol == nm1) begin
              lcol <= '0;
              if (lrow == nm1) begin
                // matrix complete: start the run with identity row order
                lrow  <= '0;
                r     <= '0;
                c     <= '0;
                state <= S_INIT;
                for (int t = 0; t < MAX_ORDER; t++) begin
                  row_order[t] <= ROW_W'(t);
                end
              end else begin
                lrow <= lrow + ROW_W'(1);
              end
            end else begin
              lcol <= lcol + ROW_W'(1);
            end
          end
        end

        S_INIT: begin
          if (c == nm1) begin
            c <= '0;
            if (r == nm1) begin
              i     <= '0;
              k     <= '0;
              state <= S_PIV_ISS;
            end else begin
              r <= r + ROW_W'(1);
            end
          end else begin
            c <= c + ROW_W'(1);
          end
        end

        S_PIV_ISS: begin
          state <= S_PIV_CMP;
        end

        S_PIV_CMP: begin
          // strictly greater wins, so the first of equal magnitudes stays
          if ((k == i) || (gj_pkg::mag32(rdata_a) > bmag)) begin
            bmag <= gj_pkg::mag32(rdata_a);
            bval <= rdata_a;
            best <= k;
          end
          if (k == nm1) begin
            state <= S_SWAP;
          end else begin
            k     <= k + ROW_W'(1);
            state <= S_PIV_ISS;
          end
        end

        S_SWAP: begin
          row_order[i]    <= row_order[best];
          row_order[best] <= row_order[i];
          pr              <= row_order[best];
          if ((bval == 32'sd0) ||
              (gj_pkg::mag32(bval) < 32'(singular_threshold))) begin
            // singular: one status item, back to loading
            result_strobe   <= 1'b1;
            inverse_element <= '0;
            status          <= 1'b1;
            last_result     <= 1'b1;
            state           <= S_LOAD;
          end else begin
            j     <= '0;
            state <= S_DIV_ISS;
          end
        end

        S_DIV_ISS: begin
          state <= S_DIV_START;
        end

        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_done) begin
            if (j == two_nm1) begin
              k     <= '0;
              state <= S_ELF_ISS;
            end else begin
              j     <= j + COL_W'(1);
              state <= S_DIV_ISS;
            end
          end
        end

        S_ELF_ISS: begin
          if (k == i) begin
            // pivot row itself is skipped
            if (k == nm1) begin
              if (i == nm1) begin
                r     <= '0;
                c     <= '0;
                state <= S_OUT_ISS;
              end else begin
                i     <= i + ROW_W'(1);
                k     <= i + ROW_W'(1);
                state <= S_PIV_ISS;
              end
            end else begin
              k <= k + ROW_W'(1);
            end
          end else begin
            kr    <= row_order[k];
            state <= S_ELF_CAP;
          end
        end

        S_ELF_CAP: begin
          f     <= rdata_a;
          j     <= '0;
          state <= S_EL_ISS;
        end

        S_EL_ISS: begin
          state <= S_EL_MUL;
        end

        S_EL_MUL: begin
          state <= S_EL_SUB;
        end

        S_EL_SUB: begin
          if (j == two_nm1) begin
            if (k == nm1) begin
              if (i == nm1) begin
                r     <= '0;
                c     <= '0;
                state <= S_OUT_ISS;
              end else begin
                i     <= i + ROW_W'(1);
                k     <= i + ROW_W'(1);
                state <= S_PIV_ISS;
              end
            end else begin
              k     <= k + ROW_W'(1);
              state <= S_ELF_ISS;
            end
          end else begin
            j     <= j + COL_W'(1);
            state <= S_EL_ISS;
          end
        end

        S_OUT_ISS: begin
          state <= S_OUT_SHOW;
        end

        S_OUT_SHOW: begin
          result_strobe   <= 1'b1;
          inverse_element <= rdata_a;
          status          <= 1'b0;
          last_result     <= (r == nm1) && (c == nm1);
          if (c == nm1) begin
            c <= '0;
            if (r == nm1) begin
              state <= S_LOAD;
            end else begin
              r     <= r + ROW_W'(1);
              state <= S_OUT_ISS;
            end
          end else begin
            c     <= c + ROW_W'(1);
            state <= S_OUT_ISS;
          end
        end

        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // a result other than the final one only appears mid-run
  a_mid_run: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last_result |-> busy)
    else $error("non-final result outside a run");

  // an accepted element never produces a result in the next cycle
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !result_strobe)
    else $error("result right after a load item");

  // singular item is alone, final and zero
  a_singular: assert property (@(posedge clk) disable iff (rst)
    result_strobe && status |-> last_result && (inverse_element == 32'sd0))
    else $error("malformed singular result");

  // the divider finishes only while the sequencer waits on it
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_WAIT))
    else $error("divider done outside its wait");

endmodule
